>>> design/srtf_pkg.sv
package srtf_pkg;

    localparam int MAX_JOBS_DEF = 16;

    localparam int ARR_W     = 16;
    localparam int TIME_W    = 21;
    localparam int IDX_OUT_W = 6;
    localparam int ORD_W     = 7;

    localparam logic [TIME_W-1:0] TIME_MAX = '1;

    typedef struct packed {
        logic [ARR_W-1:0] arrival_time;
        logic [ARR_W-1:0] run_time;
        logic             last_job;
    } t_job_req;

    typedef struct packed {
        logic [IDX_OUT_W-1:0] job_index;
        logic [TIME_W-1:0]    start_time;
        logic [TIME_W-1:0]    finish_time;
        logic [TIME_W-1:0]    turnaround_time;
        logic [ORD_W-1:0]     completion_order;
        logic                 last_result;
    } t_job_res;

endpackage

>>> design/srtf_stream_if.sv
interface srtf_stream_if #(
    parameter type T = logic
) ();
    logic valid;
    logic ready;
    T     payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

>>> design/shortest_remaining_time_scheduler.sv
// Preemptive shortest-remaining-time-first scheduler. Jobs are loaded one request per
// cycle on i_job (arrival, run time; a run time of zero counts as one); jobs beyond
// MAX_JOBS are dropped. The request flagged last_job starts the schedule: the block then
// steps from event to event (a completion or an arrival), and every event is one pass
// over the single job memory, one entry read per cycle, then ST_PICK picks the run
// length and ST_UPDATE writes it back; there are at most 2n events for n jobs.
// Ties go to the lowest job index. Afterwards one result per job leaves on o_res in
// index order, each read, loaded and held until taken. Times saturate at 2097151.
// No new job is accepted until the last result is taken; the block then starts clean.
module shortest_remaining_time_scheduler #(
    parameter int MAX_JOBS = srtf_pkg::MAX_JOBS_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    srtf_stream_if.sink    i_job,
    srtf_stream_if.source  o_res
);
    import srtf_pkg::*;

    localparam int AW       = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
    localparam int CNT_W    = $clog2(MAX_JOBS + 1);
    localparam int TICK_RAW = ARR_W + $clog2(MAX_JOBS + 1);
    localparam int TICK_W   = (TICK_RAW > TIME_W) ? TICK_RAW : TIME_W + 1;

    typedef struct packed {
        logic [ARR_W-1:0]  arrival;
        logic [ARR_W-1:0]  remaining;
        logic [TICK_W-1:0] start;
        logic [TICK_W-1:0] finish;
        logic [ORD_W-1:0]  order;
    } t_job_rec;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_SCAN,
        ST_PICK,
        ST_UPDATE,
        ST_OUT_RD,
        ST_OUT_LD,
        ST_OUT_HOLD
    } t_state;

    function automatic logic [TIME_W-1:0] sat_time(input logic [TICK_W-1:0] t);
        if (t > TICK_W'(TIME_MAX)) begin
            return TIME_MAX;
        end
        return t[TIME_W-1:0];
    endfunction

    t_state            r_state;
    t_job_rec          r_job_mem [MAX_JOBS];
    t_job_rec          r_rd_data;

    logic [CNT_W-1:0]  r_job_cnt;
    logic [CNT_W-1:0]  r_done_cnt;
    logic [TICK_W-1:0] r_tick;
    logic [MAX_JOBS-1:0] r_done;
    logic [MAX_JOBS-1:0] r_started;

    logic [AW-1:0]     r_rd_idx;
    logic              r_issuing;
    logic              r_chk_vld;
    logic [AW-1:0]     r_chk_idx;
    logic              r_chk_last;

    logic              r_have_best;
    logic [AW-1:0]     r_best_idx;
    t_job_rec          r_best_rec;
    logic              r_fut_vld;
    logic [ARR_W-1:0]  r_fut;
    logic [ARR_W-1:0]  r_run;

    logic [AW-1:0]     r_out_idx;
    logic              r_out_vld;
    t_job_res          r_res;

    logic              w_in_fire;
    logic              w_room;
    logic [AW-1:0]     w_last_idx;
    logic              w_rd_en;
    logic [AW-1:0]     w_rd_addr;
    logic              w_we;
    logic [AW-1:0]     w_waddr;
    t_job_rec          w_wdata;
    logic              w_arrived;
    logic              w_chk_done;
    logic [ARR_W-1:0]  w_gap;
    logic [ARR_W-1:0]  w_new_rem;
    logic [TICK_W-1:0] w_new_tick;
    logic              w_finishing;

    assign i_job.ready = i_rst_n && (r_state == ST_LOAD);
    assign w_in_fire   = i_job.valid && i_job.ready;
    assign w_room      = (r_job_cnt < CNT_W'(MAX_JOBS));
    assign w_last_idx  = AW'(r_job_cnt - 1'b1);

    assign o_res.valid   = r_out_vld;
    assign o_res.payload = r_res;

    assign w_arrived   = (TICK_W'(r_rd_data.arrival) <= r_tick);
    assign w_chk_done  = r_done[r_chk_idx];
    // the nearest future arrival is above the current tick, so the tick fits ARR_W here
    assign w_gap       = r_fut - r_tick[ARR_W-1:0];
    assign w_new_rem   = r_best_rec.remaining - r_run;
    assign w_new_tick  = r_tick + TICK_W'(r_run);
    assign w_finishing = (w_new_rem == '0);

    assign w_rd_en   = ((r_state == ST_SCAN) && r_issuing) || (r_state == ST_OUT_RD);
    assign w_rd_addr = (r_state == ST_OUT_RD) ? r_out_idx : r_rd_idx;

    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_best_idx;
        w_wdata = r_best_rec;
        unique case (r_state)
            ST_LOAD: begin
                w_we              = w_in_fire && w_room;
                w_waddr           = r_job_cnt[AW-1:0];
                w_wdata           = '0;
                w_wdata.arrival   = i_job.payload.arrival_time;
                w_wdata.remaining = (i_job.payload.run_time == '0) ? ARR_W'(1)
                                                                   : i_job.payload.run_time;
            end
            ST_UPDATE: begin
                w_we              = 1'b1;
                w_wdata.remaining = w_new_rem;
                if (!r_started[r_best_idx]) begin
                    w_wdata.start = r_tick;
                end
                if (w_finishing) begin
                    w_wdata.finish = w_new_tick;
                    w_wdata.order  = ORD_W'(r_done_cnt) + ORD_W'(1);
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_job_mem[w_waddr] <= w_wdata;
        end
        if (w_rd_en) begin
            r_rd_data <= r_job_mem[w_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_LOAD;
            r_job_cnt   <= '0;
            r_done_cnt  <= '0;
            r_tick      <= '0;
            r_done      <= '0;
            r_started   <= '0;
            r_issuing   <= 1'b0;
            r_chk_vld   <= 1'b0;
            r_have_best <= 1'b0;
            r_fut_vld   <= 1'b0;
            r_out_vld   <= 1'b0;
        end else begin
            unique case (r_state)
                ST_LOAD: begin
                    if (w_in_fire) begin
                        if (w_room) begin
                            r_job_cnt <= r_job_cnt + 1'b1;
                        end
                        if (i_job.payload.last_job) begin
                            r_state     <= ST_SCAN;
                            r_rd_idx    <= '0;
                            r_issuing   <= 1'b1;
                            r_chk_vld   <= 1'b0;
                            r_have_best <= 1'b0;
                            r_fut_vld   <= 1'b0;
                        end
                    end
                end
                ST_SCAN: begin
                    // issue side: one memory read per cycle
                    r_chk_vld <= r_issuing;
                    if (r_issuing) begin
                        r_chk_idx  <= r_rd_idx;
                        r_chk_last <= (r_rd_idx == w_last_idx);
                        if (r_rd_idx == w_last_idx) begin
                            r_issuing <= 1'b0;
                        end else begin
                            r_rd_idx <= r_rd_idx + 1'b1;
                        end
                    end
                    // check side: data of the read issued last cycle
                    if (r_chk_vld) begin
                        if (!w_chk_done && w_arrived &&
                            (!r_have_best || r_rd_data.remaining < r_best_rec.remaining)) begin
                            r_have_best <= 1'b1;
                            r_best_idx  <= r_chk_idx;
                            r_best_rec  <= r_rd_data;
                        end
                        if (!w_chk_done && !w_arrived &&
                            (!r_fut_vld || r_rd_data.arrival < r_fut)) begin
                            r_fut_vld <= 1'b1;
                            r_fut     <= r_rd_data.arrival;
                        end
                        if (r_chk_last) begin
                            r_state <= ST_PICK;
                        end
                    end
                end
                ST_PICK: begin
                    if (!r_have_best) begin
                        // nothing ready: jump to the next arrival
                        r_tick      <= TICK_W'(r_fut);
                        r_state     <= ST_SCAN;
                        r_rd_idx    <= '0;
                        r_issuing   <= 1'b1;
                        r_chk_vld   <= 1'b0;
                        r_fut_vld   <= 1'b0;
                    end else begin
                        r_run   <= (r_fut_vld && w_gap < r_best_rec.remaining) ? w_gap
                                                                  : r_best_rec.remaining;
                        r_state <= ST_UPDATE;
                    end
                end
                ST_UPDATE: begin
                    r_tick                <= w_new_tick;
                    r_started[r_best_idx] <= 1'b1;
                    if (w_finishing) begin
                        r_done[r_best_idx] <= 1'b1;
                        r_done_cnt         <= r_done_cnt + 1'b1;
                    end
                    if (w_finishing && (r_done_cnt + 1'b1 == r_job_cnt)) begin
                        r_state   <= ST_OUT_RD;
                        r_out_idx <= '0;
                    end else begin
                        r_state     <= ST_SCAN;
                        r_rd_idx    <= '0;
                        r_issuing   <= 1'b1;
                        r_chk_vld   <= 1'b0;
                        r_have_best <= 1'b0;
                        r_fut_vld   <= 1'b0;
                    end
                end
                ST_OUT_RD: begin
                    r_state <= ST_OUT_LD;
                end
                ST_OUT_LD: begin
                    r_res.job_index        <= IDX_OUT_W'(r_out_idx);
                    r_res.start_time       <= sat_time(r_rd_data.start);
                    r_res.finish_time      <= sat_time(r_rd_data.finish);
                    r_res.turnaround_time  <= sat_time(r_rd_data.finish
                                                       - TICK_W'(r_rd_data.arrival));
                    r_res.completion_order <= r_rd_data.order;
                    r_res.last_result      <= (r_out_idx == w_last_idx);
                    r_out_vld              <= 1'b1;
                    r_state                <= ST_OUT_HOLD;
                end
                ST_OUT_HOLD: begin
                    if (o_res.ready) begin
                        r_out_vld <= 1'b0;
                        if (r_out_idx == w_last_idx) begin
                            r_state    <= ST_LOAD;
                            r_job_cnt  <= '0;
                            r_done_cnt <= '0;
                            r_tick     <= '0;
                            r_done     <= '0;
                            r_started  <= '0;
                        end else begin
                            r_out_idx <= r_out_idx + 1'b1;
                            r_state   <= ST_OUT_RD;
                        end
                    end
                end
                default: r_state <= ST_LOAD;
            endcase
        end
    end

    a_results_after_all_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid |-> (r_done_cnt == r_job_cnt))
        else $error("result shown before every job finished");

    a_job_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_job_cnt <= CNT_W'(MAX_JOBS) && r_done_cnt <= r_job_cnt)
        else $error("job or completion count out of range");

    a_run_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_UPDATE) |-> (r_run != '0 && r_run <= r_best_rec.remaining))
        else $error("run length zero or above remaining time");

    a_tick_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_UPDATE || r_state == ST_PICK) |=> (r_tick >= $past(r_tick)))
        else $error("schedule clock went backwards");

    a_no_load_while_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_LOAD) |-> !w_we || (r_state == ST_UPDATE))
        else $error("memory written outside load or update");

endmodule
